/* rtl/fcpi_pkg.sv */
`default_nettype none
package fcpi_pkg;

   localparam int CURVE_POINTS = 8;
   localparam int POINT_W = $clog2(CURVE_POINTS);

   // register map
   typedef enum logic [2:0] {
      CSR_CURVE_TEMPS  = 3'd0,
      CSR_CURVE_SPEEDS = 3'd1,
      CSR_ROW_COUNT    = 3'd2,
      CSR_COSINE_MODE  = 3'd3,
      CSR_AGGRESSIVE   = 3'd4,
      CSR_PWM_FLOOR    = 3'd5,
      CSR_PWM_CEILING  = 3'd6
   } csr_index_type;

   localparam logic [19:0] FAULT_LIMIT      = 20'd10000;
   localparam logic [19:0] SAT_LIMIT        = 20'd256000;   // 256 degrees and up saturate
   localparam logic [17:0] MILLI_PER_DEGREE = 18'd1000;
   localparam logic [10:0] RECIP_1000       = 11'd1048;     // 2^20 / 1000, rounded down
   localparam int          RECIP_1000_SHIFT = 20;
   localparam logic [7:0]  DEGREE_MAX       = 8'd255;
   localparam logic [6:0]  PERCENT_MAX      = 7'd100;
   localparam logic [12:0] RECIP_100        = 13'd5243;     // 2^19 / 100, rounded up
   localparam int          RECIP_100_SHIFT  = 19;
   localparam logic [16:0] COS_ONE          = 17'd65536;
   localparam int          COS_SHIFT        = 16;

   // round(65536*(1-cos(pi*t/100))/2)
   localparam logic [16:0] COS_WEIGHT [0:100] = '{
      17'd0, 17'd16, 17'd65, 17'd145, 17'd258, 17'd403, 17'd580, 17'd789, 17'd1029,
      17'd1301, 17'd1604, 17'd1937, 17'd2301, 17'd2695, 17'd3119, 17'd3571, 17'd4053,
      17'd4563, 17'd5101, 17'd5666, 17'd6258, 17'd6876, 17'd7520, 17'd8188, 17'd8881,
      17'd9598, 17'd10337, 17'd11098, 17'd11881, 17'd12684, 17'd13507, 17'd14350,
      17'd15210, 17'd16088, 17'd16982, 17'd17892, 17'd18816, 17'd19754, 17'd20705,
      17'd21668, 17'd22642, 17'd23626, 17'd24619, 17'd25620, 17'd26628, 17'd27642,
      17'd28661, 17'd29684, 17'd30710, 17'd31739, 17'd32768, 17'd33797, 17'd34826,
      17'd35852, 17'd36875, 17'd37894, 17'd38908, 17'd39916, 17'd40917, 17'd41910,
      17'd42894, 17'd43868, 17'd44831, 17'd45782, 17'd46720, 17'd47644, 17'd48554,
      17'd49448, 17'd50326, 17'd51186, 17'd52029, 17'd52852, 17'd53655, 17'd54438,
      17'd55199, 17'd55938, 17'd56655, 17'd57348, 17'd58016, 17'd58660, 17'd59278,
      17'd59870, 17'd60435, 17'd60973, 17'd61483, 17'd61965, 17'd62417, 17'd62841,
      17'd63235, 17'd63599, 17'd63932, 17'd64235, 17'd64507, 17'd64747, 17'd64956,
      17'd65133, 17'd65278, 17'd65391, 17'd65471, 17'd65520, 17'd65536
   };

   typedef struct packed {
      logic [63:0] temps;
      logic [63:0] speeds;
      logic [3:0]  row_count;
      logic        cosine;
      logic        aggressive;
   } cfg_type;

   typedef struct packed {
      logic       valid;
      logic       fault;
      logic [7:0] deg;
   } deg_word_type;

   typedef struct packed {
      logic        valid;
      logic        fault;
      logic [7:0]  deg;
      logic        hold;
      logic [6:0]  hold_pct;
      logic [6:0]  s0;
      logic [6:0]  s1;
      logic [14:0] num;
      logic [7:0]  gap;
   } seg_word_type;

   typedef struct packed {
      logic       valid;
      logic       fault;
      logic [7:0] deg;
      logic       hold;
      logic [6:0] hold_pct;
      logic [6:0] s0;
      logic [6:0] s1;
      logic [6:0] t;
   } div_word_type;

   typedef struct packed {
      logic       valid;
      logic       fault;
      logic [7:0] deg;
      logic [6:0] pct;
   } pct_word_type;

   function automatic logic [16:0] cos_weight(logic [6:0] t);
      if (t > 7'd100) begin
         return 17'd0;
      end
      return COS_WEIGHT[t];
   endfunction

   // exact floor(x/100) for x below 43690
   function automatic logic [7:0] div100(logic [14:0] x);
      logic [27:0] p;
      p = 28'(x) * 28'(RECIP_100);
      return 8'(p >> RECIP_100_SHIFT);
   endfunction

endpackage
`default_nettype wire

/* rtl/fcpi_degrees.sv */
`default_nettype none
module fcpi_degrees (
   input  wire logic                   clock,
   input  wire logic                   reset,
   input  wire logic                   advance,
   input  wire logic                   in_valid,
   input  wire logic [19:0]            in_milli,
   output fcpi_pkg::deg_word_type      out_ff
);

   typedef struct packed {
      logic        valid;
      logic        fault;
      logic        sat;
      logic [17:0] milli;
      logic [7:0]  q_est;
   } est_type;

   est_type                est_ff, est_in;
   fcpi_pkg::deg_word_type out_in;
   logic [28:0]            prod;
   logic [17:0]            rem;

   // estimate is floor or floor-1 below saturation
   always_comb begin
      prod         = 29'(in_milli[17:0]) * 29'(fcpi_pkg::RECIP_1000);
      est_in.valid = in_valid;
      est_in.fault = in_milli < fcpi_pkg::FAULT_LIMIT;
      est_in.sat   = in_milli >= fcpi_pkg::SAT_LIMIT;
      est_in.milli = in_milli[17:0];
      est_in.q_est = 8'(prod >> fcpi_pkg::RECIP_1000_SHIFT);
   end

   always_comb begin
      rem          = est_ff.milli - 18'(18'(est_ff.q_est) * fcpi_pkg::MILLI_PER_DEGREE);
      out_in.valid = est_ff.valid;
      out_in.fault = est_ff.fault;
      if (est_ff.sat) begin
         out_in.deg = fcpi_pkg::DEGREE_MAX;
      end else if (rem >= fcpi_pkg::MILLI_PER_DEGREE) begin
         out_in.deg = est_ff.q_est + 8'd1;
      end else begin
         out_in.deg = est_ff.q_est;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         est_ff.valid <= 1'b0;
         out_ff.valid <= 1'b0;
      end else if (advance) begin
         est_ff <= est_in;
         out_ff <= out_in;
      end
   end

endmodule
`default_nettype wire

/* rtl/fcpi_segment.sv */
`default_nettype none
module fcpi_segment (
   input  wire logic                   clock,
   input  wire logic                   reset,
   input  wire logic                   advance,
   input  wire fcpi_pkg::cfg_type      cfg,
   input  wire fcpi_pkg::deg_word_type in_word,
   output fcpi_pkg::seg_word_type      out_ff
);

   localparam int PW = fcpi_pkg::POINT_W;

   fcpi_pkg::seg_word_type out_in;
   logic [3:0]    rows;
   logic [PW-1:0] last_idx;
   logic [PW-1:0] idx;
   logic [PW-1:0] idx_up;
   logic          hold_first;
   logic          hold_last;
   logic [7:0]    t0;
   logic [7:0]    t1;
   logic [7:0]    diff;

   function automatic logic [7:0] temp_at(logic [63:0] w, logic [PW-1:0] i);
      return w[8*i +: 8];
   endfunction

   function automatic logic [6:0] speed_at(logic [63:0] w, logic [PW-1:0] i);
      logic [7:0] s;
      s = w[8*i +: 8];
      return (s > 8'(fcpi_pkg::PERCENT_MAX)) ? fcpi_pkg::PERCENT_MAX : s[6:0];
   endfunction

   always_comb begin
      if (cfg.row_count == 4'd0) begin
         rows = 4'd1;
      end else if (cfg.row_count > 4'(fcpi_pkg::CURVE_POINTS)) begin
         rows = 4'(fcpi_pkg::CURVE_POINTS);
      end else begin
         rows = cfg.row_count;
      end
      last_idx = PW'(rows - 4'd1);

      // first segment whose upper point lies above the reading
      idx = last_idx;
      for (int i = fcpi_pkg::CURVE_POINTS - 2; i >= 0; i--) begin
         if (4'(i + 1) < rows && in_word.deg < temp_at(cfg.temps, PW'(i + 1))) begin
            idx = PW'(i);
         end
      end
      idx_up = idx + PW'(1);

      hold_first = (in_word.deg < temp_at(cfg.temps, '0)) ||
                   (cfg.aggressive && idx == '0);
      hold_last  = idx == last_idx;

      t0   = temp_at(cfg.temps, idx);
      t1   = temp_at(cfg.temps, idx_up);
      diff = (in_word.deg > t0) ? in_word.deg - t0 : 8'd0;

      out_in.valid    = in_word.valid;
      out_in.fault    = in_word.fault;
      out_in.deg      = in_word.deg;
      out_in.hold     = hold_first || hold_last;
      out_in.hold_pct = hold_first ? speed_at(cfg.speeds, '0) : speed_at(cfg.speeds, last_idx);
      out_in.s0       = speed_at(cfg.speeds, idx);
      out_in.s1       = speed_at(cfg.speeds, idx_up);
      if (hold_first || hold_last) begin
         out_in.num = 15'd0;
         out_in.gap = 8'd1;
      end else begin
         out_in.num = 15'(diff) * 15'(fcpi_pkg::PERCENT_MAX);
         out_in.gap = (t1 > t0) ? t1 - t0 : 8'd1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         out_ff.valid <= 1'b0;
      end else if (advance) begin
         out_ff <= out_in;
      end
   end

endmodule
`default_nettype wire

/* rtl/fcpi_divider.sv */
`default_nettype none
module fcpi_divider (
   input  wire logic                   clock,
   input  wire logic                   reset,
   input  wire logic                   advance,
   input  wire fcpi_pkg::seg_word_type in_word,
   output fcpi_pkg::div_word_type      out_word
);

   // restoring division, 7 quotient bits over three stages (3, 2, 2).
   // num < 100*gap, so the top 8 bits of num already sit below gap.
   typedef struct packed {
      logic        valid;
      logic        fault;
      logic [7:0]  deg;
      logic        hold;
      logic [6:0]  hold_pct;
      logic [6:0]  s0;
      logic [6:0]  s1;
      logic [14:0] num;
      logic [7:0]  gap;
      logic [7:0]  rem;
      logic [6:0]  q;
   } work_type;

   work_type init;
   work_type st1_ff, st2_ff, st3_ff;
   work_type st1_in, st2_in, st3_in;

   function automatic work_type div_bits(work_type w, int hi, int lo);
      work_type   r;
      logic [8:0] trial;
      r = w;
      for (int k = 6; k >= 0; k--) begin
         if (k <= hi && k >= lo) begin
            trial = {r.rem, r.num[k]};
            if (trial >= {1'b0, r.gap}) begin
               r.rem  = 8'(trial - {1'b0, r.gap});
               r.q[k] = 1'b1;
            end else begin
               r.rem = trial[7:0];
            end
         end
      end
      return r;
   endfunction

   always_comb begin
      init.valid    = in_word.valid;
      init.fault    = in_word.fault;
      init.deg      = in_word.deg;
      init.hold     = in_word.hold;
      init.hold_pct = in_word.hold_pct;
      init.s0       = in_word.s0;
      init.s1       = in_word.s1;
      init.num      = in_word.num;
      init.gap      = in_word.gap;
      init.rem      = in_word.num[14:7];
      init.q        = 7'd0;
      st1_in        = div_bits(init, 6, 4);
      st2_in        = div_bits(st1_ff, 3, 2);
      st3_in        = div_bits(st2_ff, 1, 0);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         st1_ff.valid <= 1'b0;
         st2_ff.valid <= 1'b0;
         st3_ff.valid <= 1'b0;
      end else if (advance) begin
         st1_ff <= st1_in;
         st2_ff <= st2_in;
         st3_ff <= st3_in;
      end
   end

   assign out_word.valid    = st3_ff.valid;
   assign out_word.fault    = st3_ff.fault;
   assign out_word.deg      = st3_ff.deg;
   assign out_word.hold     = st3_ff.hold;
   assign out_word.hold_pct = st3_ff.hold_pct;
   assign out_word.s0       = st3_ff.s0;
   assign out_word.s1       = st3_ff.s1;
   assign out_word.t        = st3_ff.q;

endmodule
`default_nettype wire

/* rtl/fcpi_blend.sv */
`default_nettype none
module fcpi_blend (
   input  wire logic                   clock,
   input  wire logic                   reset,
   input  wire logic                   advance,
   input  wire logic                   cosine,
   input  wire fcpi_pkg::div_word_type in_word,
   output fcpi_pkg::pct_word_type      out_ff
);

   typedef struct packed {
      logic        valid;
      logic        fault;
      logic [7:0]  deg;
      logic        hold;
      logic [6:0]  hold_pct;
      logic [6:0]  s0;
      logic [6:0]  s1;
      logic [16:0] wa;
      logic [16:0] wb;
   } wt_type;

   typedef struct packed {
      logic        valid;
      logic        fault;
      logic [7:0]  deg;
      logic        hold;
      logic [6:0]  hold_pct;
      logic [22:0] sum;
   } sum_type;

   wt_type                 wt_ff, wt_in;
   sum_type                sum_ff, sum_in;
   fcpi_pkg::pct_word_type out_in;
   logic [16:0]            w;

   // weights: linear (100-t, t), cosine (1-w, w) in Q0.16
   always_comb begin
      w              = fcpi_pkg::cos_weight(in_word.t);
      wt_in.valid    = in_word.valid;
      wt_in.fault    = in_word.fault;
      wt_in.deg      = in_word.deg;
      wt_in.hold     = in_word.hold;
      wt_in.hold_pct = in_word.hold_pct;
      wt_in.s0       = in_word.s0;
      wt_in.s1       = in_word.s1;
      if (cosine) begin
         wt_in.wa = fcpi_pkg::COS_ONE - w;
         wt_in.wb = w;
      end else begin
         wt_in.wa = 17'(fcpi_pkg::PERCENT_MAX - in_word.t);
         wt_in.wb = 17'(in_word.t);
      end
   end

   always_comb begin
      sum_in.valid    = wt_ff.valid;
      sum_in.fault    = wt_ff.fault;
      sum_in.deg      = wt_ff.deg;
      sum_in.hold     = wt_ff.hold;
      sum_in.hold_pct = wt_ff.hold_pct;
      sum_in.sum      = 23'(24'(wt_ff.s0) * 24'(wt_ff.wa) + 24'(wt_ff.s1) * 24'(wt_ff.wb));
   end

   always_comb begin
      out_in.valid = sum_ff.valid;
      out_in.fault = sum_ff.fault;
      out_in.deg   = sum_ff.deg;
      if (sum_ff.hold) begin
         out_in.pct = sum_ff.hold_pct;
      end else if (cosine) begin
         out_in.pct = 7'(sum_ff.sum >> fcpi_pkg::COS_SHIFT);
      end else begin
         out_in.pct = 7'(fcpi_pkg::div100(sum_ff.sum[14:0]));
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wt_ff.valid  <= 1'b0;
         sum_ff.valid <= 1'b0;
         out_ff.valid <= 1'b0;
      end else if (advance) begin
         wt_ff  <= wt_in;
         sum_ff <= sum_in;
         out_ff <= out_in;
      end
   end

endmodule
`default_nettype wire

/* rtl/fan_curve_pwm_interpolator_top.sv */
`default_nettype none
// A word accepted on req moves through every stage in order and leaves from the output register.
// Throughput: one word per cycle while rsp is not stalled; the whole pipeline moves as one,
// so an rsp stall on a waiting word freezes every stage and req_stall follows it in the same cycle.
// Reset (synchronous): clears every stage's valid bit and loads the
// register defaults; no clearing pass, req is taken from the next cycle.
module fan_curve_pwm_interpolator_top (
   input  wire logic        clock,
   input  wire logic        reset,
   // input words
   input  wire logic        req_valid,
   output logic             req_stall,
   input  wire logic [19:0] req_millidegrees,
   // result words
   output logic             rsp_valid,
   input  wire logic        rsp_stall,
   output logic             rsp_sensor_fault,
   output logic [7:0]       rsp_temperature_degrees,
   output logic [6:0]       rsp_speed_percent,
   output logic [7:0]       rsp_pwm_level,
   // register writes
   input  wire logic        csr_write,
   input  wire logic [2:0]  csr_index,
   input  wire logic [63:0] csr_data
);

   typedef struct packed {
      logic        valid;
      logic        fault;
      logic [7:0]  deg;
      logic [6:0]  pct;
      logic [14:0] prod;
   } prod_type;

   // configuration registers
   logic [63:0] temps_ff;
   logic [63:0] speeds_ff;
   logic [3:0]  row_count_ff;
   logic        cosine_ff;
   logic        aggressive_ff;
   logic [7:0]  pwm_floor_ff;
   logic [7:0]  pwm_ceiling_ff;

   fcpi_pkg::cfg_type      cfg;
   fcpi_pkg::deg_word_type deg_word;
   fcpi_pkg::seg_word_type seg_word;
   fcpi_pkg::div_word_type div_word;
   fcpi_pkg::pct_word_type pct_word;

   prod_type    prod_ff, prod_in;
   logic [7:0]  span;
   logic        advance;

   logic        rsp_valid_ff;
   logic        rsp_fault_ff;
   logic [7:0]  rsp_deg_ff;
   logic [6:0]  rsp_pct_ff;
   logic [7:0]  rsp_pwm_ff;

   // The output register is the only place a word can wait; the pipeline
   // steps whenever it is empty or being drained.
   assign advance   = !rsp_valid_ff || !rsp_stall;
   assign req_stall = !advance;

   always_ff @(posedge clock) begin
      if (reset) begin
         temps_ff       <= 64'd0;
         speeds_ff      <= 64'd0;
         row_count_ff   <= 4'd1;
         cosine_ff      <= 1'b0;
         aggressive_ff  <= 1'b0;
         pwm_floor_ff   <= 8'd0;
         pwm_ceiling_ff <= 8'd255;
      end else if (csr_write) begin
         case (csr_index)
            fcpi_pkg::CSR_CURVE_TEMPS:  temps_ff       <= csr_data;
            fcpi_pkg::CSR_CURVE_SPEEDS: speeds_ff      <= csr_data;
            fcpi_pkg::CSR_ROW_COUNT:    row_count_ff   <= csr_data[3:0];
            fcpi_pkg::CSR_COSINE_MODE:  cosine_ff      <= csr_data[0];
            fcpi_pkg::CSR_AGGRESSIVE:   aggressive_ff  <= csr_data[0];
            fcpi_pkg::CSR_PWM_FLOOR:    pwm_floor_ff   <= csr_data[7:0];
            fcpi_pkg::CSR_PWM_CEILING:  pwm_ceiling_ff <= csr_data[7:0];
            default: ;
         endcase
      end
   end

   assign cfg.temps      = temps_ff;
   assign cfg.speeds     = speeds_ff;
   assign cfg.row_count  = row_count_ff;
   assign cfg.cosine     = cosine_ff;
   assign cfg.aggressive = aggressive_ff;

   // span is clamped at zero; the floor is not added back to the level
   assign span = (pwm_ceiling_ff > pwm_floor_ff) ? pwm_ceiling_ff - pwm_floor_ff : 8'd0;

   // stages 1-2: fault check, whole degrees
   fcpi_degrees u_degrees (
      .clock    (clock),
      .reset    (reset),
      .advance  (advance),
      .in_valid (req_valid),
      .in_milli (req_millidegrees),
      .out_ff   (deg_word)
   );

   // stage 3: segment search, endpoint fetch, numerator and gap
   fcpi_segment u_segment (
      .clock   (clock),
      .reset   (reset),
      .advance (advance),
      .cfg     (cfg),
      .in_word (deg_word),
      .out_ff  (seg_word)
   );

   // stages 4-6: position t within the segment, 0..99
   fcpi_divider u_divider (
      .clock    (clock),
      .reset    (reset),
      .advance  (advance),
      .in_word  (seg_word),
      .out_word (div_word)
   );

   // stages 7-9: weights, weighted sum, scale back to percent
   fcpi_blend u_blend (
      .clock   (clock),
      .reset   (reset),
      .advance (advance),
      .cosine  (cosine_ff),
      .in_word (div_word),
      .out_ff  (pct_word)
   );

   // stage 10: percent times span
   always_comb begin
      prod_in.valid = pct_word.valid;
      prod_in.fault = pct_word.fault;
      prod_in.deg   = pct_word.deg;
      prod_in.pct   = pct_word.pct;
      prod_in.prod  = 15'(pct_word.pct) * 15'(span);
   end

   // stage 11: divide by 100 into the output register; a faulty reading
   // reports zeros in every field but the flag
   always_ff @(posedge clock) begin
      if (reset) begin
         prod_ff.valid <= 1'b0;
         rsp_valid_ff  <= 1'b0;
      end else if (advance) begin
         prod_ff      <= prod_in;
         rsp_valid_ff <= prod_ff.valid;
         rsp_fault_ff <= prod_ff.fault;
         if (prod_ff.fault) begin
            rsp_deg_ff <= 8'd0;
            rsp_pct_ff <= 7'd0;
            rsp_pwm_ff <= 8'd0;
         end else begin
            rsp_deg_ff <= prod_ff.deg;
            rsp_pct_ff <= prod_ff.pct;
            rsp_pwm_ff <= fcpi_pkg::div100(prod_ff.prod);
         end
      end
   end

   assign rsp_valid               = rsp_valid_ff;
   assign rsp_sensor_fault        = rsp_fault_ff;
   assign rsp_temperature_degrees = rsp_deg_ff;
   assign rsp_speed_percent       = rsp_pct_ff;
   assign rsp_pwm_level           = rsp_pwm_ff;

endmodule
`default_nettype wire

/* verif/tb_fan_curve_pwm_interpolator_top.sv */
module tb_fan_curve_pwm_interpolator_top;
   timeunit 1ns;
   timeprecision 1ps;

   // one result word as the block presents it
   typedef struct packed {
      logic       fault;
      logic [7:0] deg;
      logic [6:0] pct;
      logic [7:0] pwm;
   } fan_word_type;

   // Scoreboard: private copy of the register file, a model of the curve
   // lookup and a queue of predicted result words in order of acceptance.
   class fan_curve_board;
      logic [63:0]  point_temps;
      logic [63:0]  point_speeds;
      logic [3:0]   points_cfg;
      logic         cosine_on;
      logic         hold_first;
      logic [7:0]   pwm_min;
      logic [7:0]   pwm_max;
      int unsigned  ease_weight [0:100];
      fan_word_type expected_words [$];
      int unsigned  mismatches;

      function new();
         real raised;
         point_temps  = '0;
         point_speeds = '0;
         points_cfg   = 4'd1;
         cosine_on    = 1'b0;
         hold_first   = 1'b0;
         pwm_min      = 8'd0;
         pwm_max      = 8'd255;
         mismatches   = 0;
         // (1 - cos(pi*k/100)) / 2 in Q0.16, rounded to nearest
         for (int k = 0; k <= 100; k++) begin
            raised = 65536.0 * (1.0 - $cos(3.141592653589793 * k / 100.0)) / 2.0;
            ease_weight[k] = $rtoi(raised + 0.5);
         end
      endfunction

      function void set_reg(fcpi_pkg::csr_index_type idx, logic [63:0] value);
         case (idx)
            fcpi_pkg::CSR_CURVE_TEMPS:  point_temps  = value;
            fcpi_pkg::CSR_CURVE_SPEEDS: point_speeds = value;
            fcpi_pkg::CSR_ROW_COUNT:    points_cfg   = value[3:0];
            fcpi_pkg::CSR_COSINE_MODE:  cosine_on    = value[0];
            fcpi_pkg::CSR_AGGRESSIVE:   hold_first   = value[0];
            fcpi_pkg::CSR_PWM_FLOOR:    pwm_min      = value[7:0];
            fcpi_pkg::CSR_PWM_CEILING:  pwm_max      = value[7:0];
            default: ;
         endcase
      endfunction

      function int unsigned temp_at(int unsigned i);
         return point_temps[8*i +: 8];
      endfunction

      // speed bytes above full scale saturate
      function int unsigned speed_at(int unsigned i);
         int unsigned s;
         s = point_speeds[8*i +: 8];
         return (s > 100) ? 100 : s;
      endfunction

      function fan_word_type fan_response(logic [19:0] milli);
         fan_word_type w;
         int unsigned  deg, rows, seg, pct, span, t0, t1, s0, s1, gap, frac, wt;
         bit           below;
         w = '0;
         if (milli < 20'd10000) begin
            w.fault = 1'b1;
            return w;
         end
         deg = milli / 1000;
         if (deg > 255) deg = 255;
         rows = (points_cfg == 0) ? 1 :
                ((points_cfg > fcpi_pkg::CURVE_POINTS) ? fcpi_pkg::CURVE_POINTS : points_cfg);
         below = deg < temp_at(0);
         // first segment whose upper point lies above the reading
         seg = rows - 1;
         for (int i = int'(rows) - 2; i >= 0; i--) begin
            if (deg < temp_at(i + 1)) seg = i;
         end
         if (below || (hold_first && seg == 0)) begin
            pct = speed_at(0);
         end else if (seg >= rows - 1) begin
            pct = speed_at(rows - 1);
         end else begin
            t0   = temp_at(seg);
            t1   = temp_at(seg + 1);
            s0   = speed_at(seg);
            s1   = speed_at(seg + 1);
            gap  = (t1 > t0) ? t1 - t0 : 1;
            frac = (deg > t0) ? ((deg - t0) * 100) / gap : 0;
            if (frac > 100) frac = 100;
            if (cosine_on) begin
               wt  = ease_weight[frac];
               pct = (s0 * (65536 - wt) + s1 * wt) >> 16;
            end else begin
               pct = (s0 * (100 - frac) + s1 * frac) / 100;
            end
         end
         span  = (pwm_max > pwm_min) ? pwm_max - pwm_min : 0;
         w.deg = deg[7:0];
         w.pct = pct[6:0];
         w.pwm = 8'((pct * span) / 100);
         return w;
      endfunction

      function void note_reading(logic [19:0] milli);
         expected_words.push_back(fan_response(milli));
      endfunction

      function int unsigned pending();
         return expected_words.size();
      endfunction

      task report_mismatch(string what, int unsigned got, int unsigned want);
         mismatches++;
         $display("%0t mismatch %s: got %0d want %0d", $realtime, what, got, want);
      endtask

      task check_word(fan_word_type got);
         fan_word_type want;
         if (expected_words.size() == 0) begin
            report_mismatch("unexpected word", got, 0);
            return;
         end
         want = expected_words.pop_front();
         if (got.fault !== want.fault) report_mismatch("sensor_fault", got.fault, want.fault);
         if (got.deg !== want.deg) report_mismatch("temperature_degrees", got.deg, want.deg);
         if (got.pct !== want.pct) report_mismatch("speed_percent", got.pct, want.pct);
         if (got.pwm !== want.pwm) report_mismatch("pwm_level", got.pwm, want.pwm);
      endtask
   endclass

   localparam int STALL_LIMIT  = 4000;   // cycles without any handshake or register write
   localparam int ITEMS_RANDOM = 128;    // words per random curve
   localparam int CURVES       = 12;
   localparam int TOTAL_WORDS  = 27 + CURVES * ITEMS_RANDOM;

   logic                    clock = 1'b0;
   logic                    reset = 1'b1;
   logic                    req_valid = 1'b0;
   logic                    req_stall;
   logic [19:0]             req_millidegrees = '0;
   logic                    rsp_valid;
   logic                    rsp_stall = 1'b0;
   logic                    rsp_sensor_fault;
   logic [7:0]              rsp_temperature_degrees;
   logic [6:0]              rsp_speed_percent;
   logic [7:0]              rsp_pwm_level;
   logic                    csr_write = 1'b0;
   fcpi_pkg::csr_index_type csr_index = fcpi_pkg::CSR_CURVE_TEMPS;
   logic [63:0]             csr_data = '0;

   fan_curve_board board = new();

   int unsigned words_sent = 0;
   int unsigned req_gap_pct = 0;
   int unsigned rsp_stall_pct = 0;
   int unsigned idle_cycles = 0;

   fan_curve_pwm_interpolator_top dut (
      .clock                   (clock),
      .reset                   (reset),
      .req_valid               (req_valid),
      .req_stall               (req_stall),
      .req_millidegrees        (req_millidegrees),
      .rsp_valid               (rsp_valid),
      .rsp_stall               (rsp_stall),
      .rsp_sensor_fault        (rsp_sensor_fault),
      .rsp_temperature_degrees (rsp_temperature_degrees),
      .rsp_speed_percent       (rsp_speed_percent),
      .rsp_pwm_level           (rsp_pwm_level),
      .csr_write               (csr_write),
      .csr_index               (csr_index),
      .csr_data                (csr_data)
   );

   always begin
      #2 clock = 1'b1;
      #2 clock = 1'b0;
   end

   // receiver back-pressure, redrawn every cycle from the current regime
   always @(negedge clock) begin
      rsp_stall <= ($urandom_range(99) < rsp_stall_pct);
   end

   // result side: every accepted word is checked against the oldest prediction
   always @(posedge clock) begin
      if (!reset && rsp_valid && !rsp_stall) begin
         board.check_word({rsp_sensor_fault, rsp_temperature_degrees,
                           rsp_speed_percent, rsp_pwm_level});
      end
   end

   // watchdog: any handshake or register write counts as progress
   always @(posedge clock) begin
      if (reset || csr_write || (req_valid && !req_stall) || (rsp_valid && !rsp_stall)) begin
         idle_cycles <= 0;
      end else begin
         idle_cycles <= idle_cycles + 1;
      end
      if (idle_cycles >= STALL_LIMIT) begin
         $display("tb_fan_curve_pwm_interpolator_top: FAIL");
         $finish;
      end
   end

   // Offer one reading; returns at the edge that takes it. The idle/stall mix
   // moves through three regimes as the run progresses: slow receiver, then
   // slow sender, then both at full rate.
   task automatic send_reading(logic [19:0] milli);
      if (words_sent < TOTAL_WORDS / 3) begin
         req_gap_pct   = 29;
         rsp_stall_pct = 87;
      end else if (words_sent < 2 * TOTAL_WORDS / 3) begin
         req_gap_pct   = 87;
         rsp_stall_pct = 29;
      end else begin
         req_gap_pct   = 0;
         rsp_stall_pct = 0;
      end
      @(negedge clock);
      while ($urandom_range(99) < req_gap_pct) begin
         req_valid <= 1'b0;
         @(negedge clock);
      end
      req_valid        <= 1'b1;
      req_millidegrees <= milli;
      @(posedge clock);
      while (req_stall) @(posedge clock);
      board.note_reading(milli);
      words_sent++;
   endtask

   // Hold off the sender until every predicted word has come back and the
   // pipeline has had time to empty; registers may only change then.
   task automatic drain_pipeline();
      @(negedge clock);
      req_valid <= 1'b0;
      while (board.pending() != 0) @(posedge clock);
      repeat (16) @(posedge clock);
   endtask

   task automatic write_reg(fcpi_pkg::csr_index_type idx, logic [63:0] value);
      @(negedge clock);
      csr_write <= 1'b1;
      csr_index <= idx;
      csr_data  <= value;
      @(posedge clock);
      board.set_reg(idx, value);
   endtask

   task automatic load_curve(logic [63:0] temps, logic [63:0] speeds, logic [3:0] rows,
                             logic cosine, logic aggressive, logic [7:0] pwm_lo,
                             logic [7:0] pwm_hi);
      drain_pipeline();
      write_reg(fcpi_pkg::CSR_CURVE_TEMPS, temps);
      write_reg(fcpi_pkg::CSR_CURVE_SPEEDS, speeds);
      write_reg(fcpi_pkg::CSR_ROW_COUNT, 64'(rows));
      write_reg(fcpi_pkg::CSR_COSINE_MODE, 64'(cosine));
      write_reg(fcpi_pkg::CSR_AGGRESSIVE, 64'(aggressive));
      write_reg(fcpi_pkg::CSR_PWM_FLOOR, 64'(pwm_lo));
      write_reg(fcpi_pkg::CSR_PWM_CEILING, 64'(pwm_hi));
      @(negedge clock);
      csr_write <= 1'b0;
   endtask

   // mostly rising point temperatures, now and then arbitrary bytes
   function automatic logic [63:0] draw_temps();
      logic [63:0] t;
      int unsigned level;
      if ($urandom_range(99) < 15) return {$urandom, $urandom};
      level = $urandom_range(60, 5);
      for (int i = 0; i < 8; i++) begin
         t[8*i +: 8] = (level > 255) ? 8'd255 : 8'(level);
         level += $urandom_range(40, 1);
      end
      return t;
   endfunction

   function automatic logic [63:0] draw_speeds();
      logic [63:0] s;
      for (int i = 0; i < 8; i++) begin
         s[8*i +: 8] = ($urandom_range(9) == 0) ? 8'($urandom) : 8'($urandom_range(110));
      end
      return s;
   endfunction

   // Readings aimed mostly inside the configured curve, with faults,
   // saturating readings and full-width noise mixed in.
   function automatic logic [19:0] draw_reading(logic [63:0] temps, logic [3:0] rows);
      int unsigned lo, hi, last, roll, swap;
      roll = $urandom_range(99);
      last = (rows == 0) ? 0 :
             ((rows > fcpi_pkg::CURVE_POINTS) ? fcpi_pkg::CURVE_POINTS - 1 : rows - 1);
      lo   = temps[7:0];
      hi   = temps[8*last +: 8];
      if (lo > hi) begin
         swap = lo;
         lo   = hi;
         hi   = swap;
      end
      lo = (lo > 5) ? lo - 5 : 0;
      hi = (hi + 5 > 255) ? 255 : hi + 5;
      if (roll < 8) return 20'($urandom_range(9999));
      if (roll < 16) return 20'($urandom);
      if (roll < 22) return 20'($urandom_range(1048575, 250000));
      return 20'($urandom_range(hi * 1000 + 999, lo * 1000));
   endfunction

   // hand-picked readings against the directed curve: faults around the
   // limit, below the first point, inside segments, on and past the last point
   localparam logic [19:0] PROBES [12] = '{
      20'd0, 20'd9999, 20'd10000, 20'd19999, 20'd20000, 20'd25500,
      20'd30000, 20'd52500, 20'd79999, 20'd80000, 20'd255999, 20'hFFFFF
   };

   initial begin
      logic [63:0] temps, speeds;
      logic [3:0]  rows;
      logic [7:0]  pwm_lo, pwm_hi;

      repeat (3) @(negedge clock);
      reset <= 1'b0;

      // register defaults straight out of reset
      send_reading(20'd0);
      send_reading(20'd15000);
      send_reading(20'hFFFFF);

      // points at 20/30/45/60/80 degrees; last speed byte is over full scale
      load_curve(64'h0000_0050_3C2D_1E14, 64'h0000_0078_5032_140A, 4'd5,
                 1'b0, 1'b0, 8'd30, 8'd200);
      foreach (PROBES[i]) send_reading(PROBES[i]);
      load_curve(64'h0000_0050_3C2D_1E14, 64'h0000_0078_5032_140A, 4'd5,
                 1'b1, 1'b1, 8'd30, 8'd200);
      foreach (PROBES[i]) send_reading(PROBES[i]);

      for (int p = 0; p < CURVES; p++) begin
         case (p)
            0: begin
               // everything at its top value, limits equal
               temps  = '1;
               speeds = '1;
               rows   = 4'hF;
               load_curve(temps, speeds, rows, 1'b1, 1'b1, 8'd255, 8'd255);
            end
            1: begin
               // everything zero, row count below range
               temps  = '0;
               speeds = '0;
               rows   = 4'd0;
               load_curve(temps, speeds, rows, 1'b0, 1'b0, 8'd0, 8'd0);
            end
            2: begin
               // full eight-point rising curve over the whole range
               temps  = 64'hFFC8_A082_6446_280A;
               speeds = 64'h6464_503C_2819_0A00;
               rows   = 4'd8;
               load_curve(temps, speeds, rows, 1'b1, 1'b0, 8'd0, 8'd255);
            end
            3: begin
               // inverted PWM limits
               temps  = draw_temps();
               speeds = draw_speeds();
               rows   = 4'($urandom_range(8, 2));
               load_curve(temps, speeds, rows, 1'b0, 1'b1, 8'd200, 8'd50);
            end
            default: begin
               temps  = draw_temps();
               speeds = draw_speeds();
               rows   = ($urandom_range(99) < 75) ? 4'($urandom_range(8, 2))
                                                  : 4'($urandom_range(15));
               pwm_lo = 8'($urandom);
               pwm_hi = 8'($urandom);
               if ($urandom_range(99) < 70 && pwm_lo > pwm_hi) begin
                  {pwm_lo, pwm_hi} = {pwm_hi, pwm_lo};
               end
               load_curve(temps, speeds, rows, 1'($urandom), 1'($urandom), pwm_lo, pwm_hi);
            end
         endcase
         for (int n = 0; n < ITEMS_RANDOM; n++) begin
            send_reading(draw_reading(temps, rows));
         end
      end

      // wait out the tail, then give the pipeline time to show any stray word
      drain_pipeline();
      repeat (24) @(posedge clock);
      if (board.mismatches == 0 && board.pending() == 0) begin
         $display("tb_fan_curve_pwm_interpolator_top: PASS");
      end else begin
         $display("tb_fan_curve_pwm_interpolator_top: FAIL");
      end
      $finish;
   end

endmodule
